/* rtl/imh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg: types and constants of the indexed min heap
// Holds the request and result structs, the action and status codes and the
// widths used by the heap sequencer and its memories.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam int unsigned TileCount = 4096;
  localparam int unsigned TileBits  = 12;
  localparam int unsigned PosBits   = 13;
  localparam int unsigned CostBits  = 32;

  localparam logic [1:0] ActUpdate = 2'd0;
  localparam logic [1:0] ActPop    = 2'd1;
  localparam logic [1:0] ActLookup = 2'd2;
  localparam logic [1:0] ActClear  = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StPopEmpty = 2'd1;
  localparam logic [1:0] StUnvisit  = 2'd2;
  localparam logic [1:0] StRemoved  = 2'd3;

  typedef struct packed {
    logic [1:0]          action;
    logic [TileBits-1:0] tile_id;
    logic [31:0]         total_cost;
    logic [31:0]         actual_cost;
    logic [TileBits-1:0] parent_tile;
  } req_t;

  typedef struct packed {
    logic [TileBits-1:0] best_tile;
    logic [31:0]         best_total_cost;
    logic [31:0]         best_actual_cost;
    logic [TileBits-1:0] best_parent;
    logic                queue_empty;
    logic [12:0]         queue_count;
    logic                tile_visited;
    logic [31:0]         tile_total_cost;
    logic [31:0]         tile_actual_cost;
    logic [TileBits-1:0] tile_parent;
    logic [1:0]          status;
  } rsp_t;

  // node record: total, actual, parent
  localparam int unsigned NodeBits = 2 * CostBits + TileBits;

endpackage

/* rtl/imh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram: generic single port ram
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/indexed_min_heap_decrease_key.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key: indexed binary min heap with decrease key
// Priority queue over tiles: update/insert, pop, lookup, clear.
// ----------------------------------------------------------------------------
//  channel | direction | payload | handshake
//  req     | in        | req_t   | req_valid_i / req_stall_o
//  rsp     | out       | rsp_t   | rsp_valid_o / rsp_stall_i
//
// one request at a time; a sequencer walks the heap over single port rams
// with one shared comparator. an update sifts its tile up one level at a
// time, a pop sifts the last tile down from the root one level at a time.
// visited marks are an epoch tag per tile; after
// reset and after every 255th clear the tags are swept, one tile per cycle,
// with the request side stalled. a result waiting on a stalled
// output holds the sequencer in its output state; the next request is taken
// as soon as the sequencer is idle.
// ----------------------------------------------------------------------------
module indexed_min_heap_decrease_key (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  imh_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output imh_pkg::rsp_t rsp_o
);

  localparam int unsigned TB = imh_pkg::TileBits;
  localparam int unsigned PB = imh_pkg::PosBits;
  localparam int unsigned CB = imh_pkg::CostBits;
  localparam int unsigned NB = imh_pkg::NodeBits;
  localparam int unsigned EB = 8;

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RNODE = 5'd2;
  localparam logic [4:0] S_CHK   = 5'd3;
  localparam logic [4:0] S_CHK2  = 5'd4;
  localparam logic [4:0] S_INS   = 5'd5;
  localparam logic [4:0] S_UP0   = 5'd6;
  localparam logic [4:0] S_UP1   = 5'd7;
  localparam logic [4:0] S_UP2   = 5'd8;
  localparam logic [4:0] S_POPA  = 5'd9;
  localparam logic [4:0] S_POPB  = 5'd10;
  localparam logic [4:0] S_POPC  = 5'd11;
  localparam logic [4:0] S_DN0   = 5'd12;
  localparam logic [4:0] S_DN1   = 5'd13;
  localparam logic [4:0] S_DN2   = 5'd14;
  localparam logic [4:0] S_DN3   = 5'd15;
  localparam logic [4:0] S_DN4   = 5'd16;
  localparam logic [4:0] S_TOPS  = 5'd17;
  localparam logic [4:0] S_TOPW  = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  // memories: slot -> tile, tile -> node record, tile -> pos, tile -> epoch
  logic          sl_we, nd_we, ps_we, ep_we;
  logic [TB-1:0] sl_a, nd_a, ps_a, ep_a;
  logic [TB-1:0] sl_wd, sl_rd;
  logic [NB-1:0] nd_wd, nd_rd;
  logic [PB-1:0] ps_wd, ps_rd;
  logic [EB-1:0] ep_wd, ep_rd;

  imh_ram #(.Width(TB), .Depth(imh_pkg::TileCount)) u_slot (
    .clk_i, .we_i(sl_we), .addr_i(sl_a), .wdata_i(sl_wd), .rdata_o(sl_rd));
  imh_ram #(.Width(NB), .Depth(imh_pkg::TileCount)) u_node (
    .clk_i, .we_i(nd_we), .addr_i(nd_a), .wdata_i(nd_wd), .rdata_o(nd_rd));
  imh_ram #(.Width(PB), .Depth(imh_pkg::TileCount)) u_pos (
    .clk_i, .we_i(ps_we), .addr_i(ps_a), .wdata_i(ps_wd), .rdata_o(ps_rd));
  imh_ram #(.Width(EB), .Depth(imh_pkg::TileCount)) u_epoch (
    .clk_i, .we_i(ep_we), .addr_i(ep_a), .wdata_i(ep_wd), .rdata_o(ep_rd));

  logic [4:0]    st_q, st_d;
  logic [PB-1:0] size_q, size_d;
  logic [EB-1:0] epoch_q, epoch_d;
  logic [TB-1:0] init_q, init_d;
  imh_pkg::req_t req_q, req_d;
  logic [PB-1:0] pos_q, pos_d;      // hole position of the moving tile
  logic [PB-1:0] oth_q, oth_d;      // partner position (parent or chosen child)
  logic [TB-1:0] ct_q, ct_d;        // moving tile
  logic [CB-1:0] cc_q, cc_d;        // cost of moving tile
  logic [TB-1:0] ot_q, ot_d;        // tile at partner
  logic [CB-1:0] oc_q, oc_d;        // cost at partner
  logic [TB-1:0] lt_q, lt_d;        // left child tile during sift down
  logic [CB-1:0] lcst_q, lcst_d;    // left child cost
  logic          hasr_q, hasr_d;
  logic [1:0]    stat_q, stat_d;
  logic          vis_q, vis_d;
  logic [NB-1:0] lk_q, lk_d;
  logic          rv_q, rv_d;
  imh_pkg::rsp_t rsp_q, rsp_d;
  logic          wipe_q, wipe_d;    // epoch wrapped, sweep again

  logic [CB-1:0] cmp_a, cmp_b;
  logic          cmp_lt;
  assign cmp_lt = cmp_a < cmp_b;    // shared compare unit

  logic          accept;
  assign req_stall_o = (st_q != S_IDLE) || wipe_q;
  assign accept      = req_valid_i && !req_stall_o;
  assign rsp_valid_o = rv_q;
  assign rsp_o       = rsp_q;

  logic [PB:0]   lc_w, rc_w;
  logic [PB-1:0] up_w;
  logic [CB-1:0] nd_cost;
  assign lc_w    = {pos_q, 1'b1};
  assign rc_w    = {pos_q + 1'b1, 1'b0};
  assign up_w    = (pos_q - 1'b1) >> 1;
  assign nd_cost = nd_rd[NB-1 -: CB];

  always_comb begin
    st_d = st_q; size_d = size_q; epoch_d = epoch_q; init_d = init_q;
    req_d = req_q; pos_d = pos_q; oth_d = oth_q; ct_d = ct_q; cc_d = cc_q;
    ot_d = ot_q; oc_d = oc_q; lt_d = lt_q; lcst_d = lcst_q; hasr_d = hasr_q;
    stat_d = stat_q; vis_d = vis_q; lk_d = lk_q; rv_d = rv_q; rsp_d = rsp_q;
    wipe_d = wipe_q;
    sl_we = 1'b0; nd_we = 1'b0; ps_we = 1'b0; ep_we = 1'b0;
    sl_a = '0; nd_a = req_q.tile_id; ps_a = ct_q; ep_a = req_q.tile_id;
    sl_wd = ct_q; ps_wd = pos_q; ep_wd = epoch_q;
    nd_wd = {req_q.total_cost, req_q.actual_cost, req_q.parent_tile};
    cmp_a = oc_q; cmp_b = cc_q;
    if (rv_q && !rsp_stall_i) rv_d = 1'b0;
    unique case (st_q)
      S_INIT: begin
        ep_we = 1'b1; ep_a = init_q; ep_wd = '0;
        init_d = init_q + 1'b1;
        if (init_q == TB'(imh_pkg::TileCount - 1)) begin
          st_d = S_IDLE; wipe_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (wipe_q) begin
          st_d = S_INIT; init_d = '0;
        end else if (accept) begin
          req_d = req_i; stat_d = imh_pkg::StOk; vis_d = 1'b0;
          unique case (req_i.action)
            imh_pkg::ActClear: begin
              size_d = '0;
              epoch_d = epoch_q + 1'b1;
              if (epoch_q == '1) begin
                epoch_d = EB'(1); wipe_d = 1'b1;
              end
              st_d = S_TOPS;
            end
            imh_pkg::ActPop: begin
              if (size_q == '0) begin
                stat_d = imh_pkg::StPopEmpty; st_d = S_TOPS;
              end else begin
                st_d = S_POPA;
              end
            end
            imh_pkg::ActUpdate, imh_pkg::ActLookup: st_d = S_RNODE;
          endcase
        end
      end
      S_RNODE: begin
        // epoch, node, pos reads in flight
        ps_a = req_q.tile_id;
        st_d = S_CHK;
      end
      S_CHK: begin
        vis_d = (ep_rd == epoch_q);
        lk_d = nd_rd;
        pos_d = ps_rd;
        cc_d = nd_cost;
        ct_d = req_q.tile_id;
        if (req_q.action == imh_pkg::ActLookup) begin
          if (ep_rd != epoch_q) stat_d = imh_pkg::StUnvisit;
          st_d = S_TOPS;
        end else if (ep_rd != epoch_q) begin
          st_d = S_INS;
        end else begin
          sl_a = ps_rd[TB-1:0];
          st_d = S_CHK2;
        end
      end
      S_CHK2: begin
        // visited: in heap if pos < size and slot matches
        if (!(pos_q < size_q && sl_rd == req_q.tile_id)) begin
          stat_d = imh_pkg::StRemoved; st_d = S_TOPS;
        end else begin
          cmp_a = req_q.total_cost; cmp_b = cc_q;
          if (cmp_lt) begin
            nd_we = 1'b1; cc_d = req_q.total_cost;
            st_d = S_UP0;
          end else begin
            st_d = S_TOPS;
          end
        end
      end
      S_INS: begin
        nd_we = 1'b1; ep_we = 1'b1;
        pos_d = size_q; size_d = size_q + 1'b1;
        cc_d = req_q.total_cost;
        st_d = S_UP0;
      end
      S_UP0: begin
        if (pos_q == '0) begin
          sl_we = 1'b1; sl_a = pos_q[TB-1:0];
          ps_we = 1'b1;
          st_d = S_TOPS;
        end else begin
          oth_d = up_w;
          sl_a = up_w[TB-1:0];
          st_d = S_UP1;
        end
      end
      S_UP1: begin
        ot_d = sl_rd; nd_a = sl_rd;
        st_d = S_UP2;
      end
      S_UP2: begin
        cmp_a = cc_q; cmp_b = nd_cost;
        sl_a = pos_q[TB-1:0];
        sl_we = 1'b1; ps_we = 1'b1;
        if (cmp_lt) begin
          // parent moves down into the hole
          sl_wd = ot_q; ps_a = ot_q;
          pos_d = oth_q;
          st_d = S_UP0;
        end else begin
          st_d = S_TOPS;
        end
      end
      S_POPA: begin
        sl_a = TB'(size_q - 1'b1);
        st_d = S_POPB;
      end
      S_POPB: begin
        // last tile becomes the moving tile, hole at the root
        ct_d = sl_rd; nd_a = sl_rd;
        size_d = size_q - 1'b1; pos_d = '0;
        st_d = S_POPC;
      end
      S_POPC: begin
        cc_d = nd_cost;
        st_d = S_DN0;
      end
      S_DN0: begin
        if (lc_w >= {1'b0, size_q}) begin
          sl_we = 1'b1; sl_a = pos_q[TB-1:0];
          ps_we = 1'b1;
          st_d = S_TOPS;
        end else begin
          sl_a = lc_w[TB-1:0];
          oth_d = lc_w[PB-1:0];
          hasr_d = rc_w < {1'b0, size_q};
          st_d = S_DN1;
        end
      end
      S_DN1: begin
        lt_d = sl_rd; ot_d = sl_rd; nd_a = sl_rd;
        sl_a = rc_w[TB-1:0];
        st_d = S_DN2;
      end
      S_DN2: begin
        lcst_d = nd_cost; oc_d = nd_cost;
        if (hasr_q) begin
          ot_d = sl_rd; nd_a = sl_rd;
          st_d = S_DN3;
        end else begin
          st_d = S_DN4;
        end
      end
      S_DN3: begin
        // equal children: right one wins
        cmp_a = lcst_q; cmp_b = nd_cost;
        if (!cmp_lt) begin
          oc_d = nd_cost; oth_d = oth_q + 1'b1;
        end else begin
          ot_d = lt_q;
        end
        st_d = S_DN4;
      end
      S_DN4: begin
        // move child up only if strictly cheaper
        cmp_a = oc_q; cmp_b = cc_q;
        sl_a = pos_q[TB-1:0];
        sl_we = 1'b1; ps_we = 1'b1;
        if (cmp_lt) begin
          sl_wd = ot_q; ps_a = ot_q;
          pos_d = oth_q;
          st_d = S_DN0;
        end else begin
          st_d = S_TOPS;
        end
      end
      S_TOPS: begin
        sl_a = '0;
        st_d = S_TOPW;
      end
      S_TOPW: begin
        nd_a = sl_rd; ct_d = sl_rd;
        st_d = S_OUT;
      end
      S_OUT: begin
        nd_a = ct_q;
        if (!rv_q || !rsp_stall_i) begin
          rsp_d = '0;
          if (size_q != '0) begin
            rsp_d.best_tile        = ct_q;
            rsp_d.best_total_cost  = nd_rd[NB-1 -: CB];
            rsp_d.best_actual_cost = nd_rd[NB-CB-1 -: CB];
            rsp_d.best_parent      = nd_rd[TB-1:0];
          end
          rsp_d.queue_empty = (size_q == '0);
          rsp_d.queue_count = size_q;
          rsp_d.status = stat_q;
          if (req_q.action == imh_pkg::ActLookup && vis_q) begin
            rsp_d.tile_visited     = 1'b1;
            rsp_d.tile_total_cost  = lk_q[NB-1 -: CB];
            rsp_d.tile_actual_cost = lk_q[NB-CB-1 -: CB];
            rsp_d.tile_parent      = lk_q[TB-1:0];
          end
          rv_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; size_q <= '0; epoch_q <= EB'(1); init_q <= '0;
      rv_q <= 1'b0; wipe_q <= 1'b0;
    end else begin
      st_q <= st_d; size_q <= size_d; epoch_q <= epoch_d; init_q <= init_d;
      rv_q <= rv_d; wipe_q <= wipe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; pos_q <= pos_d; oth_q <= oth_d; ct_q <= ct_d; cc_q <= cc_d;
    ot_q <= ot_d; oc_q <= oc_d; lt_q <= lt_d; lcst_q <= lcst_d; hasr_q <= hasr_d;
    stat_q <= stat_d; vis_q <= vis_d; lk_q <= lk_d; rsp_q <= rsp_d;
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the indexed min heap with decrease key
// Drives update, pop, lookup and clear requests with bursty valid and a
// stalling receiver, predicts every result with a local heap model and checks
// each whole result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  imh_pkg::req_t req_i;
  logic rsp_valid_o;
  logic rsp_stall_i = 1'b0;
  imh_pkg::rsp_t rsp_o;

  indexed_min_heap_decrease_key dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid_i), .req_stall_o(req_stall_o), .req_i(req_i),
    .rsp_valid_o(rsp_valid_o), .rsp_stall_i(rsp_stall_i), .rsp_o(rsp_o)
  );

  // local copy of the heap
  logic [11:0] slot_tile [imh_pkg::TileCount];
  logic [12:0] heap_count;
  logic [31:0] tile_tcost [imh_pkg::TileCount];
  logic [31:0] tile_acost [imh_pkg::TileCount];
  logic [11:0] tile_par [imh_pkg::TileCount];
  logic [12:0] tile_pos [imh_pkg::TileCount];
  logic        tile_seen [imh_pkg::TileCount];

  imh_pkg::rsp_t pending_rsp [$];
  int     errors = 0;
  longint cycles = 0;
  int     stall_mode = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] cost_at(int p);
    return tile_tcost[slot_tile[p]];
  endfunction

  function automatic void swap_pos(int a, int b);
    logic [11:0] ta, tb2;
    ta = slot_tile[a];
    tb2 = slot_tile[b];
    slot_tile[a] = tb2;
    slot_tile[b] = ta;
    tile_pos[tb2] = 13'(a);
    tile_pos[ta] = 13'(b);
  endfunction

  function automatic void bubble_up(int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (cost_at(p) < cost_at(up)) begin
        swap_pos(p, up);
        p = up;
      end else break;
    end
  endfunction

  function automatic void bubble_down();
    int p, lc, rc, pick;
    p = 0;
    forever begin
      lc = 2 * p + 1;
      rc = lc + 1;
      if (lc >= heap_count) break;
      // equal children: right one wins
      if (rc < heap_count && !(cost_at(lc) < cost_at(rc))) pick = rc;
      else pick = lc;
      if (cost_at(p) > cost_at(pick)) begin
        swap_pos(p, pick);
        p = pick;
      end else break;
    end
  endfunction

  function automatic logic queued(logic [11:0] t);
    return tile_pos[t] < heap_count && slot_tile[tile_pos[t]] == t;
  endfunction

  function automatic imh_pkg::rsp_t apply_request(imh_pkg::req_t r);
    imh_pkg::rsp_t o;
    logic [11:0] t, last;
    o = '0;
    t = r.tile_id;
    o.status = imh_pkg::StOk;
    case (r.action)
      imh_pkg::ActUpdate: begin
        if (!tile_seen[t]) begin
          tile_tcost[t] = r.total_cost;
          tile_acost[t] = r.actual_cost;
          tile_par[t] = r.parent_tile;
          tile_pos[t] = heap_count;
          slot_tile[heap_count] = t;
          heap_count++;
          tile_seen[t] = 1'b1;
          bubble_up(heap_count - 1);
        end else if (!queued(t)) begin
          o.status = imh_pkg::StRemoved;
        end else if (r.total_cost < tile_tcost[t]) begin
          tile_tcost[t] = r.total_cost;
          tile_acost[t] = r.actual_cost;
          tile_par[t] = r.parent_tile;
          bubble_up(tile_pos[t]);
        end
      end
      imh_pkg::ActPop: begin
        if (heap_count == '0) begin
          o.status = imh_pkg::StPopEmpty;
        end else begin
          last = slot_tile[heap_count - 1];
          slot_tile[0] = last;
          tile_pos[last] = '0;
          heap_count--;
          bubble_down();
        end
      end
      imh_pkg::ActLookup: begin
        if (!tile_seen[t]) begin
          o.status = imh_pkg::StUnvisit;
        end else begin
          o.tile_visited = 1'b1;
          o.tile_total_cost = tile_tcost[t];
          o.tile_actual_cost = tile_acost[t];
          o.tile_parent = tile_par[t];
        end
      end
      default: begin
        heap_count = '0;
        foreach (tile_seen[i]) tile_seen[i] = 1'b0;
      end
    endcase
    if (heap_count > 0) begin
      o.best_tile = slot_tile[0];
      o.best_total_cost = tile_tcost[slot_tile[0]];
      o.best_actual_cost = tile_acost[slot_tile[0]];
      o.best_parent = tile_par[slot_tile[0]];
    end else begin
      o.queue_empty = 1'b1;
    end
    o.queue_count = heap_count;
    return o;
  endfunction

  // send one request, predict at acceptance
  task automatic send_req(logic [1:0] act, logic [11:0] t, logic [31:0] tc,
                          logic [31:0] ac, logic [11:0] par);
    imh_pkg::req_t r;
    r.action = act;
    r.tile_id = t;
    r.total_cost = tc;
    r.actual_cost = ac;
    r.parent_tile = par;
    req_i <= r;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (req_stall_o);
    pending_rsp = {pending_rsp, apply_request(r)};
  endtask

  int burst_left;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // pick a tile that is not yet visited
  function automatic logic [11:0] fresh_tile();
    logic [11:0] t;
    t = 12'($urandom);
    while (tile_seen[t]) t = 12'($urandom);
    return t;
  endfunction

  task automatic test_directed();
    send_req(imh_pkg::ActPop, 12'd0, '0, '0, '0);
    send_req(imh_pkg::ActLookup, 12'd4095, '0, '0, '0);
    send_req(imh_pkg::ActUpdate, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    send_req(imh_pkg::ActUpdate, 12'd4095, 32'd0, 32'd0, 12'd0);
    send_req(imh_pkg::ActUpdate, 12'd7, 32'd100, 32'h5555_5555, 12'hAAA);
    send_req(imh_pkg::ActUpdate, 12'd8, 32'd100, 32'hAAAA_AAAA, 12'h555);
    send_req(imh_pkg::ActUpdate, 12'd9, 32'd100, 32'd3, 12'd1);
    send_req(imh_pkg::ActUpdate, 12'd7, 32'd200, 32'd1, 12'd2); // not lower: no change
    send_req(imh_pkg::ActUpdate, 12'd7, 32'd100, 32'd1, 12'd2); // equal: no change
    send_req(imh_pkg::ActUpdate, 12'd0, 32'd50, 32'd9, 12'd3);  // decrease key
    send_req(imh_pkg::ActLookup, 12'd0, '0, '0, '0);
    send_req(imh_pkg::ActLookup, 12'd4095, '0, '0, '0);
    send_req(imh_pkg::ActPop, '0, '0, '0, '0);
    send_req(imh_pkg::ActUpdate, 12'd4095, 32'd1, 32'd1, 12'd1); // removed tile
    send_req(imh_pkg::ActLookup, 12'd4095, '0, '0, '0);          // removed tile lookup
    send_req(imh_pkg::ActPop, '0, '0, '0, '0);
    send_req(imh_pkg::ActPop, '0, '0, '0, '0);
    send_req(imh_pkg::ActPop, '0, '0, '0, '0);
    send_req(imh_pkg::ActPop, '0, '0, '0, '0);
    send_req(imh_pkg::ActPop, '0, '0, '0, '0);
    send_req(imh_pkg::ActUpdate, 12'd5, 32'd10, 32'd10, 12'd5);
    send_req(imh_pkg::ActClear, '0, '0, '0, '0);
    send_req(imh_pkg::ActLookup, 12'd5, '0, '0, '0);
    send_req(imh_pkg::ActUpdate, 12'd5, 32'd11, 32'd12, 12'd6);
  endtask

  // router-like traffic: inserts, decreases, pops, lookups and updates of random tiles, clears
  task automatic test_random(int n);
    int k, sel;
    logic [11:0] t;
    logic [31:0] c;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      c = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
      if (sel < 40 && heap_count < 4000) begin
        send_req(imh_pkg::ActUpdate, fresh_tile(), c, $urandom, 12'($urandom));
      end else if (sel < 55 && heap_count > 0) begin
        t = slot_tile[$urandom_range(0, heap_count - 1)];
        send_req(imh_pkg::ActUpdate, t, 32'(tile_tcost[t] - $urandom_range(0, 30)),
                 $urandom, 12'($urandom));
      end else if (sel < 80) begin
        send_req(imh_pkg::ActPop, 12'($urandom), $urandom, $urandom, 12'($urandom));
      end else if (sel < 96) begin
        send_req(sel < 88 ? imh_pkg::ActLookup : imh_pkg::ActUpdate, 12'($urandom),
                 c, $urandom, 12'($urandom));
      end else if (sel < 98) begin
        send_req(imh_pkg::ActClear, 12'($urandom), $urandom, $urandom, 12'($urandom));
      end else begin
        drain(); // let the block run dry mid stream
      end
      pace();
    end
  endtask

  // a long climb: many inserts then all pops, exercising deep sifts
  task automatic test_deep();
    int k;
    send_req(imh_pkg::ActClear, '0, '0, '0, '0);
    for (k = 0; k < 150; k++) begin
      send_req(imh_pkg::ActUpdate, fresh_tile(), $urandom_range(0, 60), $urandom,
               12'($urandom));
      pace();
    end
    for (k = 0; k < 155; k++) begin
      send_req(imh_pkg::ActPop, '0, '0, '0, '0);
      pace();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    imh_pkg::rsp_t e;
    if (rst_ni && rsp_valid_o && !rsp_stall_i) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t unexpected result %p", $time, rsp_o);
        errors++;
      end else begin
        e = pending_rsp.pop_front();
        if (rsp_o !== e) begin
          $display("%0t mismatch: expected %p actual %p", $time, e, rsp_o);
          errors++;
        end
      end
    end
  end

  // receiver stall pattern, phases change every so often
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_stall_i <= 1'b0;
      1: rsp_stall_i <= ($urandom_range(0, 3) == 0);
      2: rsp_stall_i <= (cycles[2:0] < 5);
      default: rsp_stall_i <= ($urandom_range(0, 1) == 0);
    endcase
    if (cycles > 64'd2000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    burst_left = 0;
    heap_count = '0;
    foreach (tile_seen[i]) tile_seen[i] = 1'b0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    drain();
    test_deep();
    test_random(700);
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
